/* sv/weyl_dominant_reflect_assert.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef WEYL_DOMINANT_REFLECT_ASSERT_SVH
`define WEYL_DOMINANT_REFLECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WDR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wdr_pkg.sv */
package wdr_pkg;

    localparam int LANES      = 8;
    localparam int COORD_W    = 24;
    localparam int ENTRY_W    = 4;
    localparam int LANE_IDX_W = 3;
    localparam int RANK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ROW_W      = LANES * ENTRY_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord [LANES-1:0]        t_vec;
    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic [LANE_IDX_W-1:0]     t_lane_idx;
    typedef logic [RANK_W-1:0]         t_rank;
    typedef logic [1:0]                t_sign;

    // Result of the lane scan handed from the scan module to the control.
    typedef struct packed {
        logic      hit;   // a zero or negative lane in use was found
        logic      wall;  // the first such lane is zero
        t_lane_idx idx;   // lowest lane that is zero or negative
    } t_scan;

    localparam t_sign SIGN_WALL  = 2'd0;
    localparam t_sign SIGN_PLUS  = 2'd1;
    localparam t_sign SIGN_MINUS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_0_1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_2_3 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_4_5 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_6_7 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK     = 3'd4;

endpackage

/* sv/wdr_if.sv */
interface wdr_in_if import wdr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord coord_0;
    t_coord coord_1;
    t_coord coord_2;
    t_coord coord_3;
    t_coord coord_4;
    t_coord coord_5;
    t_coord coord_6;
    t_coord coord_7;

    modport source (output valid, coord_0, coord_1, coord_2, coord_3, coord_4, coord_5,
                    coord_6, coord_7, input ready);
    modport sink (input valid, coord_0, coord_1, coord_2, coord_3, coord_4, coord_5,
                  coord_6, coord_7, output ready);
endinterface

interface wdr_out_if import wdr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord out_coord_0;
    t_coord out_coord_1;
    t_coord out_coord_2;
    t_coord out_coord_3;
    t_coord out_coord_4;
    t_coord out_coord_5;
    t_coord out_coord_6;
    t_coord out_coord_7;
    t_sign  sign_code;
    logic   error;

    modport source (output valid, out_coord_0, out_coord_1, out_coord_2, out_coord_3,
                    out_coord_4, out_coord_5, out_coord_6, out_coord_7, sign_code, error,
                    input ready);
    modport sink (input valid, out_coord_0, out_coord_1, out_coord_2, out_coord_3,
                  out_coord_4, out_coord_5, out_coord_6, out_coord_7, sign_code, error,
                  output ready);
endinterface

interface wdr_cfg_if import wdr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/wdr_lane.sv */
module wdr_lane import wdr_pkg::*; (
    input  t_coord i_v,
    input  t_coord i_ci,
    input  t_entry i_entry,
    input  logic   i_in_use,
    output t_coord o_nv,
    output logic   o_ovf
);

    localparam int PROD_W = COORD_W + ENTRY_W;
    localparam int DIFF_W = PROD_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [DIFF_W-1:0] diff;
    logic                     fits;

    always_comb begin
        prod = PROD_W'(i_ci) * PROD_W'(i_entry);
        diff = DIFF_W'(i_v) - DIFF_W'(prod);
        // The difference fits when all bits above the coordinate sign agree.
        fits = (diff[DIFF_W-1:COORD_W-1] == '0) || (diff[DIFF_W-1:COORD_W-1] == '1);
        o_ovf = i_in_use && !fits;
        o_nv  = i_in_use ? diff[COORD_W-1:0] : i_v;
    end

endmodule

/* sv/wdr_scan.sv */
module wdr_scan import wdr_pkg::*; (
    input  t_vec  i_vec,
    input  t_rank i_rank,
    output t_scan o_scan
);

    always_comb begin
        o_scan = '0;
        // Walk from the top lane down so that the lowest qualifying lane wins.
        for (int i = LANES - 1; i >= 0; i--) begin
            if ((RANK_W'(i) < i_rank) && (i_vec[i] <= 0)) begin
                o_scan.hit  = 1'b1;
                o_scan.wall = (i_vec[i] == 0);
                o_scan.idx  = LANE_IDX_W'(i);
            end
        end
    end

endmodule

/* sv/weyl_dominant_reflect.sv */
// Moves a weight vector of up to eight signed 24-bit coordinates into the
// dominant chamber by simple reflections, using the Cartan matrix and lane
// count held in the configuration registers, and returns the final vector, the
// sign (wall, plus or minus) and an error flag for overflow or the reflection
// bound. One item is worked on at a time: after the request is accepted the
// block performs one reflection per cycle, with all lanes updated in parallel,
// and then a final scan; the result is held back only while an earlier result
// is still waiting to be taken. The next request is accepted from the cycle in
// which the result appears. Configuration requests are always taken and must
// only be issued while the block is idle.
`include "weyl_dominant_reflect_assert.svh"

module weyl_dominant_reflect import wdr_pkg::*; #(
    parameter int MAX_RANK        = 8,
    parameter int MAX_REFLECTIONS = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wdr_cfg_if.sink         i_cfg,
    wdr_in_if.sink          i_in,
    wdr_out_if.source       o_out
);

    localparam int    CNT_W     = $clog2(MAX_REFLECTIONS + 1);
    localparam t_rank RANK_MAX  = RANK_W'(MAX_RANK);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_REFLECTIONS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_DATA_W-1:0] r_cartan [4];
    t_rank                 r_rank;
    t_vec                  r_v, n_v;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    t_vec                  r_out_vec, n_out_vec;
    t_sign                 r_out_sign, n_out_sign;
    logic                  r_out_err, n_out_err;

    t_rank                 eff_rank;
    t_vec                  in_vec;
    t_scan                 scan;
    t_coord                ci;
    logic [CFG_DATA_W-1:0] row_pair;
    logic [ROW_W-1:0]      row;
    t_vec                  lane_nv;
    logic [LANES-1:0]      lane_ovf;
    logic [LANES-1:0]      lane_use;
    logic                  out_free;
    logic                  in_req;

    always_comb begin
        if (r_rank == '0) begin
            eff_rank = RANK_W'(1);
        end else if (r_rank > RANK_MAX) begin
            eff_rank = RANK_MAX;
        end else begin
            eff_rank = r_rank;
        end
    end

    assign in_vec = {i_in.coord_7, i_in.coord_6, i_in.coord_5, i_in.coord_4,
                     i_in.coord_3, i_in.coord_2, i_in.coord_1, i_in.coord_0};

    wdr_scan u_scan (
        .i_vec  (r_v),
        .i_rank (eff_rank),
        .o_scan (scan)
    );

    assign ci       = r_v[scan.idx];
    assign row_pair = r_cartan[scan.idx[LANE_IDX_W-1:1]];
    assign row      = scan.idx[0] ? row_pair[2*ROW_W-1:ROW_W] : row_pair[ROW_W-1:0];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        assign lane_use[k] = (RANK_W'(k) < eff_rank);

        wdr_lane u_lane (
            .i_v      (r_v[k]),
            .i_ci     (ci),
            .i_entry  (t_entry'(row[k*ENTRY_W +: ENTRY_W])),
            .i_in_use (lane_use[k]),
            .o_nv     (lane_nv[k]),
            .o_ovf    (lane_ovf[k])
        );
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_req      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_neg       = r_neg;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_vec   = r_out_vec;
        n_out_sign  = r_out_sign;
        n_out_err   = r_out_err;

        case (r_state)
            S_IDLE: begin
                if (in_req) begin
                    for (int i = 0; i < LANES; i++) begin
                        n_v[i] = lane_use[i] ? in_vec[i] : '0;
                    end
                    n_neg   = 1'b0;
                    n_count = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (scan.hit && !scan.wall && (r_count != CNT_LIMIT) && (lane_ovf == '0)) begin
                    n_v     = lane_nv;
                    n_neg   = !r_neg;
                    n_count = r_count + CNT_W'(1);
                end else if (out_free) begin
                    // Finished: wall, dominant, bound reached or overflow.
                    n_out_valid = 1'b1;
                    n_out_vec   = r_v;
                    n_out_err   = scan.hit && !scan.wall;
                    if (!scan.hit) begin
                        n_out_sign = r_neg ? SIGN_MINUS : SIGN_PLUS;
                    end else begin
                        n_out_sign = SIGN_WALL;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rank      <= RANK_W'(8);
            r_count     <= '0;
            for (int m = 0; m < 4; m++) begin
                r_cartan[m] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_ROWS_0_1: r_cartan[0] <= i_cfg.data;
                    CFG_ROWS_2_3: r_cartan[1] <= i_cfg.data;
                    CFG_ROWS_4_5: r_cartan[2] <= i_cfg.data;
                    CFG_ROWS_6_7: r_cartan[3] <= i_cfg.data;
                    CFG_RANK:     r_rank      <= i_cfg.data[RANK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_neg      <= n_neg;
        r_out_vec  <= n_out_vec;
        r_out_sign <= n_out_sign;
        r_out_err  <= n_out_err;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_coord_0 = r_out_vec[0];
    assign o_out.out_coord_1 = r_out_vec[1];
    assign o_out.out_coord_2 = r_out_vec[2];
    assign o_out.out_coord_3 = r_out_vec[3];
    assign o_out.out_coord_4 = r_out_vec[4];
    assign o_out.out_coord_5 = r_out_vec[5];
    assign o_out.out_coord_6 = r_out_vec[6];
    assign o_out.out_coord_7 = r_out_vec[7];
    assign o_out.sign_code   = r_out_sign;
    assign o_out.error       = r_out_err;

    `WDR_ASSERT_SAME(a_err_sign, i_clk, i_rst_n, r_out_valid && r_out_err,
        r_out_sign == SIGN_WALL, "error result must carry the wall sign")
    `WDR_ASSERT_SAME(a_sign_code, i_clk, i_rst_n, r_out_valid,
        r_out_sign != 2'd3, "sign code out of range")
    `WDR_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, r_state == S_RUN,
        r_count <= CNT_LIMIT, "reflection count beyond bound")
    `WDR_ASSERT_NEXT(a_accept_run, i_clk, i_rst_n, in_req,
        r_state == S_RUN && r_count == '0, "accepted request did not start a run")
    `WDR_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, r_out_valid && !o_out.ready,
        r_out_valid && $stable(r_out_vec), "pending result was lost or changed")

endmodule

/* sim/tb_weyl_dominant_reflect.sv */
`timescale 1ns / 1ps

module tb_weyl_dominant_reflect;
    import wdr_pkg::*;

    localparam int REFL_LIMIT      = 128;
    localparam int COORD_HI        = 8388607;
    localparam int COORD_LO        = -8388608;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = REFL_LIMIT + 22;
    localparam int PHASES          = 15;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int LONG_HOLD       = 400;
    localparam int SHOWN_LIMIT     = 200;

    typedef struct packed {
        t_vec  coord;
        t_sign sign;
        logic  err;
    } t_weyl_res;

    typedef logic [3:0][CFG_DATA_W-1:0] t_cartan_set;

    typedef enum {
        MAT_ZERO, MAT_DIAG, MAT_A, MAT_B, MAT_C, MAT_D, MAT_E8, MAT_F4, MAT_G2,
        MAT_RAND_CARTAN, MAT_RAND_NIB
    } t_cartan_kind;

    typedef enum {W_TYPICAL, W_TINY, W_WIDE, W_NOISE} t_weight_style;

    typedef struct {
        t_cartan_kind mat;
        t_rank        rank;
        t_vec         w;
        bit           typed;
        t_weyl_res    want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wdr_in_if  weights_if ();
    wdr_out_if refl_if ();
    wdr_cfg_if cfg_if ();

    weyl_dominant_reflect #(
        .MAX_RANK(8),
        .MAX_REFLECTIONS(REFL_LIMIT)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(cfg_if),
        .i_in(weights_if),
        .o_out(refl_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the register file, updated on each accepted write.
    t_cartan_set  cartan_shadow = '0;
    t_rank        rank_shadow   = t_rank'(8);
    t_cartan_kind cur_mat       = MAT_ZERO;
    t_rank        cur_rank      = t_rank'(8);

    t_weyl_res     due_results[$];
    t_directed_row directed_rows[$];

    int mismatches    = 0;
    int shown         = 0;
    int sent          = 0;
    int results_seen  = 0;
    int n_plus        = 0;
    int n_minus       = 0;
    int n_wall        = 0;
    int n_err         = 0;
    int n_settings    = 0;
    int cycle_count   = 0;
    int send_gap_pct  = 20;
    int recv_gap_pct  = 5;
    int stall_left    = 0;
    bit long_hold_done = 1'b0;

    function automatic int cartan_at(input int i, input int k);
        logic [3:0] nib;
        nib = cartan_shadow[i >> 1][(i & 1) * 32 + k * 4 +: 4];
        return int'($signed(nib));
    endfunction

    function automatic t_weyl_res reflect_to_dominant(input t_vec w);
        longint    v [LANES];
        longint    nv [LANES];
        longint    pivot;
        int        lanes;
        int        bad;
        int        steps;
        bit        flipped;
        bit        wall;
        bit        ovf;
        bit        settled;
        t_weyl_res res;
        lanes = (rank_shadow == 0) ? 1 : (rank_shadow > LANES) ? LANES : int'(rank_shadow);
        res = '0;
        res.sign = SIGN_WALL;
        steps = 0;
        flipped = 1'b0;
        settled = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            v[i] = (i < lanes) ? longint'($signed(w[i])) : 0;
        end
        while (!settled) begin
            bad = -1;
            wall = 1'b0;
            for (int i = 0; i < lanes && bad < 0 && !wall; i++) begin
                if (v[i] < 0) begin
                    bad = i;
                end else if (v[i] == 0) begin
                    wall = 1'b1;
                end
            end
            if (wall) begin
                settled = 1'b1;
            end else if (bad < 0) begin
                res.sign = flipped ? SIGN_MINUS : SIGN_PLUS;
                settled = 1'b1;
            end else if (steps >= REFL_LIMIT) begin
                res.err = 1'b1;
                settled = 1'b1;
            end else begin
                pivot = v[bad];
                ovf = 1'b0;
                for (int k = 0; k < lanes; k++) begin
                    nv[k] = v[k] - pivot * cartan_at(bad, k);
                    if (nv[k] < COORD_LO || nv[k] > COORD_HI) begin
                        ovf = 1'b1;
                    end
                end
                if (ovf) begin
                    res.err = 1'b1;
                    settled = 1'b1;
                end else begin
                    for (int k = 0; k < lanes; k++) begin
                        v[k] = nv[k];
                    end
                    flipped = !flipped;
                    steps++;
                end
            end
        end
        for (int i = 0; i < LANES; i++) begin
            res.coord[i] = t_coord'(v[i]);
        end
        return res;
    endfunction

    // Diagonal entries are 2 except for the zero and random-nibble matrices.
    // Finite types keep walks short; random ones run into the bound and overflow.
    function automatic t_cartan_set build_cartan(input t_cartan_kind kind);
        int          m [LANES][LANES];
        int          ea [7] = '{0, 2, 3, 4, 5, 6, 1};
        int          eb [7] = '{2, 3, 4, 5, 6, 7, 3};
        int          off;
        t_cartan_set regs;
        regs = '0;
        for (int i = 0; i < LANES; i++) begin
            for (int k = 0; k < LANES; k++) begin
                m[i][k] = (i == k && kind != MAT_ZERO) ? 2 : 0;
            end
        end
        case (kind)
            MAT_A, MAT_B, MAT_C: begin
                for (int i = 0; i < LANES - 1; i++) begin
                    m[i][i + 1] = -1;
                    m[i + 1][i] = -1;
                end
            end
            MAT_D: begin
                for (int i = 0; i < LANES - 2; i++) begin
                    m[i][i + 1] = -1;
                    m[i + 1][i] = -1;
                end
                m[5][7] = -1;
                m[7][5] = -1;
            end
            MAT_E8: begin
                for (int e = 0; e < 7; e++) begin
                    m[ea[e]][eb[e]] = -1;
                    m[eb[e]][ea[e]] = -1;
                end
            end
            MAT_F4: begin
                m[0][1] = -1;
                m[1][0] = -1;
                m[1][2] = -2;
                m[2][1] = -1;
                m[2][3] = -1;
                m[3][2] = -1;
            end
            MAT_G2: begin
                m[0][1] = -1;
                m[1][0] = -3;
            end
            MAT_RAND_CARTAN: begin
                for (int i = 0; i < LANES; i++) begin
                    for (int k = 0; k < LANES; k++) begin
                        off = $urandom_range(0, 6);
                        if (i != k) begin
                            m[i][k] = (off < 3) ? 0 : 2 - off;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (kind == MAT_B) begin
            m[6][7] = -2;
        end
        if (kind == MAT_C) begin
            m[7][6] = -2;
        end
        for (int i = 0; i < LANES; i++) begin
            for (int k = 0; k < LANES; k++) begin
                regs[i / 2][(i % 2) * 32 + k * 4 +: 4] = 4'(m[i][k]);
            end
        end
        if (kind == MAT_RAND_NIB) begin
            regs = {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
        end
        return regs;
    endfunction

    function automatic t_vec vec8(input int c0, input int c1, input int c2, input int c3,
                                  input int c4, input int c5, input int c6, input int c7);
        t_vec v;
        v[0] = t_coord'(c0);
        v[1] = t_coord'(c1);
        v[2] = t_coord'(c2);
        v[3] = t_coord'(c3);
        v[4] = t_coord'(c4);
        v[5] = t_coord'(c5);
        v[6] = t_coord'(c6);
        v[7] = t_coord'(c7);
        return v;
    endfunction

    function automatic t_vec random_weight(input t_weight_style style);
        t_vec w;
        int   mag;
        mag = (style == W_TINY) ? 4 : (style == W_WIDE) ? (1 << 20) : 2000;
        for (int i = 0; i < LANES; i++) begin
            if (style == W_NOISE) begin
                case ($urandom_range(0, 7))
                    0: w[i] = t_coord'(COORD_LO);
                    1: w[i] = t_coord'(COORD_HI);
                    default: w[i] = t_coord'($urandom);
                endcase
            end else begin
                w[i] = t_coord'(int'($urandom_range(0, 2 * mag)) - mag);
            end
        end
        return w;
    endfunction

    task automatic add_row(input t_cartan_kind mat, input int rank, input t_vec w,
                           input bit typed, input t_vec want_v, input t_sign want_s,
                           input logic want_e);
        t_directed_row row;
        row.mat = mat;
        row.rank = t_rank'(rank);
        row.w = w;
        row.typed = typed;
        row.want.coord = want_v;
        row.want.sign = want_s;
        row.want.err = want_e;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Leaves valid high so that back-to-back writes need no second assignment.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx <= CFG_ROWS_6_7) begin
            cartan_shadow[idx[1:0]] = val;
        end else if (idx == CFG_RANK) begin
            rank_shadow = val[RANK_W-1:0];
        end
    endtask

    // Registers may only change once the block has drained every request.
    task automatic apply_setting(input t_cartan_kind kind, input t_rank rank);
        t_cartan_set           regs;
        logic [CFG_DATA_W-1:0] rank_word;
        weights_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        regs = build_cartan(kind);
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_ROWS_0_1 + CFG_IDX_W'(m), regs[m]);
        end
        rank_word = {$urandom, $urandom};
        rank_word[RANK_W-1:0] = rank;
        write_reg(CFG_RANK, rank_word);
        // Indexes past the rank register hold nothing and must be ignored.
        write_reg(CFG_RANK + 3'($urandom_range(1, 3)), {$urandom, $urandom});
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        cur_mat = kind;
        cur_rank = rank;
        n_settings++;
    endtask

    task automatic push_weight(input t_vec w, input bit typed, input t_weyl_res want);
        weights_if.valid <= 1'b1;
        weights_if.coord_0 <= w[0];
        weights_if.coord_1 <= w[1];
        weights_if.coord_2 <= w[2];
        weights_if.coord_3 <= w[3];
        weights_if.coord_4 <= w[4];
        weights_if.coord_5 <= w[5];
        weights_if.coord_6 <= w[6];
        weights_if.coord_7 <= w[7];
        do @(posedge i_clk); while (!weights_if.ready);
        due_results.insert(due_results.size(), typed ? want : reflect_to_dominant(w));
        sent++;
    endtask

    task automatic report_miss(input string what, input longint want, input longint got);
        mismatches++;
        if (shown < SHOWN_LIMIT) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            shown++;
        end
    endtask

    task automatic check_result();
        t_weyl_res got;
        t_weyl_res want;
        got.coord = {refl_if.out_coord_7, refl_if.out_coord_6, refl_if.out_coord_5,
                     refl_if.out_coord_4, refl_if.out_coord_3, refl_if.out_coord_2,
                     refl_if.out_coord_1, refl_if.out_coord_0};
        got.sign = refl_if.sign_code;
        got.err = refl_if.error;
        results_seen++;
        if (due_results.size() == 0) begin
            report_miss("result with no request pending, sign", -1, got.sign);
            return;
        end
        want = due_results.pop_front();
        if (want.err) begin
            n_err++;
        end else if (want.sign == SIGN_PLUS) begin
            n_plus++;
        end else if (want.sign == SIGN_MINUS) begin
            n_minus++;
        end else begin
            n_wall++;
        end
        for (int i = 0; i < LANES; i++) begin
            if (got.coord[i] !== want.coord[i]) begin
                report_miss($sformatf("lane %0d", i), $signed(want.coord[i]),
                            $signed(got.coord[i]));
            end
        end
        if (got.sign !== want.sign) begin
            report_miss("sign_code", want.sign, got.sign);
        end
        if (got.err !== want.err) begin
            report_miss("error", want.err, got.err);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        refl_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && refl_if.valid && refl_if.ready) begin
                check_result();
                if (!long_hold_done && results_seen >= 250) begin
                    stall_left = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                refl_if.ready <= 1'b0;
            end else if (recv_gap_pct > 0 && $urandom_range(0, 99) < recv_gap_pct) begin
                stall_left = $urandom_range(1, 14) - 1;
                refl_if.ready <= 1'b0;
            end else begin
                refl_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_count, due_results.size());
            $display("weyl_dominant_reflect: mismatch");
            $finish;
        end
    end

    initial begin
        t_cartan_kind  plan_mat [PHASES] = '{MAT_E8, MAT_A, MAT_D, MAT_E8, MAT_E8, MAT_B,
                                             MAT_C, MAT_F4, MAT_G2, MAT_RAND_CARTAN,
                                             MAT_RAND_NIB, MAT_RAND_CARTAN, MAT_A, MAT_D,
                                             MAT_E8};
        int            plan_rank [PHASES] = '{8, 15, 9, 6, 7, 8, 8, 4, 2, -1, -1, -1, 1, 5, 8};
        t_directed_row row;
        t_weight_style style;
        int            pick;
        t_rank         rank;

        i_rst_n <= 1'b0;
        weights_if.valid <= 1'b0;
        weights_if.coord_0 <= '0;
        weights_if.coord_1 <= '0;
        weights_if.coord_2 <= '0;
        weights_if.coord_3 <= '0;
        weights_if.coord_4 <= '0;
        weights_if.coord_5 <= '0;
        weights_if.coord_6 <= '0;
        weights_if.coord_7 <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset matrix of zeros a negative lane never changes, so the
        // walk runs into the reflection bound and returns the input untouched.
        add_row(MAT_ZERO, 8, vec8(COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                                  COORD_HI, COORD_HI, COORD_HI, COORD_HI), 1'b1,
                vec8(COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                     COORD_HI, COORD_HI, COORD_HI, COORD_HI), SIGN_PLUS, 1'b0);
        add_row(MAT_ZERO, 8, vec8(1, 1, 1, 1, 1, 1, 1, 1), 1'b1,
                vec8(1, 1, 1, 1, 1, 1, 1, 1), SIGN_PLUS, 1'b0);
        add_row(MAT_ZERO, 8, vec8(0, COORD_HI, COORD_HI, COORD_HI, 1, 1, 1, 1), 1'b1,
                vec8(0, COORD_HI, COORD_HI, COORD_HI, 1, 1, 1, 1), SIGN_WALL, 1'b0);
        add_row(MAT_ZERO, 8, vec8(COORD_LO, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                vec8(COORD_LO, 0, 0, 0, 0, 0, 0, 0), SIGN_WALL, 1'b1);
        add_row(MAT_ZERO, 8, vec8(5, 5, 5, 5, 5, 5, 5, -1), 1'b1,
                vec8(5, 5, 5, 5, 5, 5, 5, -1), SIGN_WALL, 1'b1);
        add_row(MAT_ZERO, 8, vec8(5, 5, 5, 5, 5, 5, 5, 0), 1'b1,
                vec8(5, 5, 5, 5, 5, 5, 5, 0), SIGN_WALL, 1'b0);
        add_row(MAT_ZERO, 8, vec8(9, 9, 9, 0, 9, -7, 9, 9), 1'b1,
                vec8(9, 9, 9, 0, 9, -7, 9, 9), SIGN_WALL, 1'b0);
        // Diagonal-only matrix on three lanes: each reflection negates one lane,
        // the lanes above the rank read back as zero.
        add_row(MAT_DIAG, 3, vec8(COORD_LO, 1, 2, -1, -1, -1, -1, -1), 1'b1,
                vec8(COORD_LO, 1, 2, 0, 0, 0, 0, 0), SIGN_WALL, 1'b1);
        add_row(MAT_DIAG, 3, vec8(-5, 7, 9, 0, 0, 0, 0, 0), 1'b1,
                vec8(5, 7, 9, 0, 0, 0, 0, 0), SIGN_MINUS, 1'b0);
        add_row(MAT_DIAG, 3, vec8(-1, -1, -1, COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                                  COORD_LO), 1'b1,
                vec8(1, 1, 1, 0, 0, 0, 0, 0), SIGN_MINUS, 1'b0);
        add_row(MAT_DIAG, 3, vec8(-1, -1, 2, COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                                  COORD_HI), 1'b1,
                vec8(1, 1, 2, 0, 0, 0, 0, 0), SIGN_PLUS, 1'b0);
        add_row(MAT_DIAG, 3, vec8(COORD_HI, -COORD_HI, 3, 0, 0, 0, 0, 0), 1'b1,
                vec8(COORD_HI, COORD_HI, 3, 0, 0, 0, 0, 0), SIGN_MINUS, 1'b0);
        add_row(MAT_DIAG, 3, vec8(0, -1, -1, 7, 7, 7, 7, 7), 1'b1,
                vec8(0, -1, -1, 0, 0, 0, 0, 0), SIGN_WALL, 1'b0);
        // A rank of zero behaves as one lane, a rank above eight as eight.
        add_row(MAT_DIAG, 0, vec8(-3, -4, -4, -4, -4, -4, -4, -4), 1'b1,
                vec8(3, 0, 0, 0, 0, 0, 0, 0), SIGN_MINUS, 1'b0);
        add_row(MAT_DIAG, 0, vec8(0, -1, -1, -1, -1, -1, -1, -1), 1'b1,
                vec8(0, 0, 0, 0, 0, 0, 0, 0), SIGN_WALL, 1'b0);
        add_row(MAT_DIAG, 15, vec8(-1, -1, -1, -1, -1, -1, -1, -1), 1'b1,
                vec8(1, 1, 1, 1, 1, 1, 1, 1), SIGN_PLUS, 1'b0);
        add_row(MAT_DIAG, 15, vec8(COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                                   COORD_LO, COORD_LO, COORD_LO, COORD_LO), 1'b1,
                vec8(COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                     COORD_LO, COORD_LO, COORD_LO, COORD_LO), SIGN_WALL, 1'b1);
        add_row(MAT_ZERO, 9, vec8(2, 2, 2, 2, 2, 2, 2, 2), 1'b1,
                vec8(2, 2, 2, 2, 2, 2, 2, 2), SIGN_PLUS, 1'b0);
        add_row(MAT_E8, 8, vec8(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0, SIGN_WALL, 1'b0);
        add_row(MAT_E8, 8, vec8(-3, 1, 4, -1, 5, -9, 2, -6), 1'b0, '0, SIGN_WALL, 1'b0);
        add_row(MAT_G2, 2, vec8(-1, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0, SIGN_WALL, 1'b0);
        add_row(MAT_A, 8, vec8(1, -2, 3, -4, 5, -6, 7, -8), 1'b0, '0, SIGN_WALL, 1'b0);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.mat != cur_mat || row.rank != cur_rank) begin
                apply_setting(row.mat, row.rank);
            end
            push_weight(row.w, row.typed, row.want);
        end

        for (int p = 0; p < PHASES; p++) begin
            rank = (plan_rank[p] < 0) ? t_rank'($urandom_range(0, 15)) : t_rank'(plan_rank[p]);
            apply_setting(plan_mat[p], rank);
            if (p == PHASES - 1) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end else begin
                pick = $urandom_range(0, 2);
                send_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
                pick = $urandom_range(0, 2);
                recv_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 3 : 12;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                style = (pick < 60) ? W_TYPICAL : (pick < 75) ? W_TINY :
                        (pick < 85) ? W_WIDE : W_NOISE;
                push_weight(random_weight(style), 1'b0, '0);
                if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
                    weights_if.valid <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge i_clk);
                end
            end
        end

        weights_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests under %0d register settings; %0d results checked.",
                 sent, n_settings, results_seen);
        $display("Outcomes: %0d plus, %0d minus, %0d on a wall, %0d flagged as errors.",
                 n_plus, n_minus, n_wall, n_err);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("weyl_dominant_reflect: match");
        end else begin
            $display("weyl_dominant_reflect: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/wdr_pkg.sv
sv/wdr_if.sv
sv/wdr_lane.sv
sv/wdr_scan.sv
sv/weyl_dominant_reflect.sv
sim/tb_weyl_dominant_reflect.sv
